[sv/pfd_pkg.sv]
// Shared types, register map and protocol constants for the pairing frame deframer.
// No dependencies; imported by every module of the block.
package pfd_pkg;

	localparam int DigestBytesDef    = 32;
	localparam int MachineIdBytesDef = 16;
	localparam int NonceBytesDef     = 32;

	localparam int AddrW = 6;
	localparam int DataW = 64;

	localparam logic [2:0] REG_MAGIC    = 3'd0;
	localparam logic [2:0] REG_VERSION  = 3'd1;
	localparam logic [2:0] REG_CAPMASK  = 3'd2;
	localparam logic [2:0] REG_MAXFRAME = 3'd3;
	localparam logic [2:0] REG_MAXNAME  = 3'd4;

	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	localparam logic [2:0] FK_UNKNOWN = 3'd0;
	localparam logic [2:0] FK_COMMIT  = 3'd1;
	localparam logic [2:0] FK_OFFER   = 3'd2;
	localparam logic [2:0] FK_CONFIRM = 3'd3;
	localparam logic [2:0] FK_DONE    = 3'd4;

	localparam logic [1:0] V_PROGRESS = 2'd0;
	localparam logic [1:0] V_VALID    = 2'd1;
	localparam logic [1:0] V_INVALID  = 2'd2;

	localparam logic [20:0] CP_MAX      = 21'h10FFFF;
	localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
	localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
	localparam logic [20:0] CP_C1_LO    = 21'h000080;
	localparam logic [20:0] CP_C1_HI    = 21'h00009F;
	localparam logic [20:0] CP_MIN2     = 21'h000080;
	localparam logic [20:0] CP_MIN3     = 21'h000800;
	localparam logic [20:0] CP_MIN4     = 21'h010000;

	typedef struct packed {
		logic [31:0] magic;
		logic [7:0]  version;
		logic [63:0] cap_mask;
		logic [15:0] max_frame;
		logic [7:0]  max_name;
	} cfg_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
	} q_item_t;

	typedef struct packed {
		logic [7:0]  body_byte;
		logic [15:0] body_offset;
		logic [2:0]  frame_kind;
		logic        frame_end;
		logic [1:0]  verdict;
	} res_t;

endpackage

[sv/pfd_regs.sv]
// APB-style configuration register file for the deframer.
// Depends on pfd_pkg (register map, cfg_t).
module pfd_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [pfd_pkg::AddrW-1:0] paddr,
	input  logic [pfd_pkg::DataW-1:0] pwdata,
	output logic [pfd_pkg::DataW-1:0] prdata,
	output logic                 pready,
	output pfd_pkg::cfg_t        cfg
);
	import pfd_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[5:3];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic     <= 32'd0;
			cfg_q.version   <= 8'd1;
			cfg_q.cap_mask  <= 64'd0;
			cfg_q.max_frame <= 16'd1024;
			cfg_q.max_name  <= 8'd64;
		end else if (wr_en) begin
			unique case (idx)
				REG_MAGIC:    cfg_q.magic     <= pwdata[31:0];
				REG_VERSION:  cfg_q.version   <= pwdata[7:0];
				REG_CAPMASK:  cfg_q.cap_mask  <= pwdata;
				REG_MAXFRAME: cfg_q.max_frame <= pwdata[15:0];
				REG_MAXNAME:  cfg_q.max_name  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAGIC:    prdata = {32'd0, cfg_q.magic};
			REG_VERSION:  prdata = {56'd0, cfg_q.version};
			REG_CAPMASK:  prdata = cfg_q.cap_mask;
			REG_MAXFRAME: prdata = {48'd0, cfg_q.max_frame};
			REG_MAXNAME:  prdata = {56'd0, cfg_q.max_name};
			default:      prdata = '0;
		endcase
	end

endmodule

[sv/pfd_queue.sv]
// Front end: accepts input transactions into a two-entry queue.
// Depends on pfd_pkg (q_item_t).
module pfd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pfd_pkg::q_item_t  in_item,
	output logic              q_valid,
	output pfd_pkg::q_item_t  q_item,
	input  logic              q_pop
);
	import pfd_pkg::*;

	q_item_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[sv/pfd_engine.sv]
// Back end: frame parser, length/UTF-8/capability checks and output register.
// Depends on pfd_pkg (cfg_t, q_item_t, res_t, protocol constants).
module pfd_engine #(
	parameter int DIGEST_BYTES     = pfd_pkg::DigestBytesDef,
	parameter int MACHINE_ID_BYTES = pfd_pkg::MachineIdBytesDef,
	parameter int NONCE_BYTES      = pfd_pkg::NonceBytesDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pfd_pkg::cfg_t    cfg,
	input  logic             q_valid,
	input  pfd_pkg::q_item_t q_item,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output pfd_pkg::res_t    res
);
	import pfd_pkg::*;

	localparam logic [16:0] OfferFixed = 17'(MACHINE_ID_BYTES + 1 + DIGEST_BYTES + NONCE_BYTES);
	localparam logic [16:0] DigestLen  = 17'(DIGEST_BYTES);
	localparam logic [16:0] ConfLen    = 17'(DIGEST_BYTES + 8);
	localparam logic [15:0] MidOff     = 16'(MACHINE_ID_BYTES);
	localparam logic [15:0] CapOff     = 16'(DIGEST_BYTES);

	logic [15:0] pos_q;
	logic [63:0] hdr_q;
	logic [2:0]  kind_q;
	logic [15:0] blen_q;
	logic [7:0]  nlen_q;
	logic [1:0]  upend_q;
	logic [20:0] ucp_q;
	logic [1:0]  ucls_q;
	logic [63:0] cap_q;
	logic        berr_q;
	logic        stuck_q;
	logic        out_valid_q;
	res_t        res_q;

	logic [15:0] pos_n;
	logic [63:0] hdr_n;
	logic [2:0]  kind_n;
	logic [15:0] blen_n;
	logic [7:0]  nlen_n;
	logic [1:0]  upend_n;
	logic [20:0] ucp_n;
	logic [1:0]  ucls_n;
	logic [63:0] cap_n;
	logic        berr_n;
	logic        stuck_n;
	logic        emit;
	res_t        r;

	logic        out_ready;
	logic        pop;

	assign out_ready = !out_valid_q || !out_stall;
	assign pop       = q_valid && out_ready;
	assign q_pop     = pop;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		logic [7:0]  b;
		logic [7:0]  typ;
		logic [15:0] len;
		logic        hdr_ok;
		logic [15:0] off;
		logic [20:0] min_cp;
		logic        clear_all;

		b       = q_item.data;
		pos_n   = pos_q;
		hdr_n   = hdr_q;
		kind_n  = kind_q;
		blen_n  = blen_q;
		nlen_n  = nlen_q;
		upend_n = upend_q;
		ucp_n   = ucp_q;
		ucls_n  = ucls_q;
		cap_n   = cap_q;
		berr_n  = berr_q;
		stuck_n = stuck_q;
		emit    = 1'b0;
		r       = '0;
		typ     = '0;
		len     = '0;
		hdr_ok  = 1'b0;
		off     = pos_q - 16'd8;
		min_cp  = CP_MIN2;
		clear_all = 1'b0;

		if (q_item.kind == KIND_CLEAR) begin
			clear_all = 1'b1;
			stuck_n   = 1'b0;
		end else if (stuck_q) begin
			emit = 1'b1;
			r    = '{8'd0, 16'd0, FK_UNKNOWN, 1'b1, V_INVALID};
		end else if (pos_q < 16'd8) begin
			hdr_n = {hdr_q[55:0], b};
			pos_n = pos_q + 16'd1;
			typ   = hdr_n[23:16];
			len   = hdr_n[15:0];
			if (pos_q == 16'd7) begin
				hdr_ok = (hdr_n[63:32] == cfg.magic) && (hdr_n[31:24] == cfg.version)
					&& (typ >= 8'd1) && (typ <= 8'd4)
					&& ({1'b0, len} + 17'd8 <= {1'b0, cfg.max_frame});
				if ((typ == 8'(FK_COMMIT) || typ == 8'(FK_DONE)) && {1'b0, len} != DigestLen)
					hdr_ok = 1'b0;
				if (typ == 8'(FK_CONFIRM) && {1'b0, len} != ConfLen)
					hdr_ok = 1'b0;
				if (typ == 8'(FK_OFFER) && {1'b0, len} < OfferFixed)
					hdr_ok = 1'b0;
				if (!hdr_ok) begin
					emit      = 1'b1;
					r         = '{8'd0, 16'd0, FK_UNKNOWN, 1'b1, V_INVALID};
					if (typ >= 8'd1 && typ <= 8'd4) r.frame_kind = typ[2:0];
					clear_all = 1'b1;
					stuck_n   = 1'b1;
				end else begin
					kind_n = typ[2:0];
					blen_n = len;
				end
			end
		end else begin
			pos_n = pos_q + 16'd1;
			if (kind_q == FK_OFFER) begin
				if (off == MidOff) begin
					nlen_n = b;
					if (b == 8'd0 || b > cfg.max_name || {1'b0, blen_q} != OfferFixed + 17'(b))
						berr_n = 1'b1;
				end else if (off > MidOff && off <= MidOff + 16'(nlen_q)) begin
					if (upend_q == 2'd0) begin
						if (b < 8'h80) begin
							if (b < 8'h20 || b == 8'h7F) berr_n = 1'b1;
						end else if ((b & 8'hE0) == 8'hC0) begin
							upend_n = 2'd1; ucp_n = 21'(b & 8'h1F); ucls_n = 2'd1;
						end else if ((b & 8'hF0) == 8'hE0) begin
							upend_n = 2'd2; ucp_n = 21'(b & 8'h0F); ucls_n = 2'd2;
						end else if ((b & 8'hF8) == 8'hF0) begin
							upend_n = 2'd3; ucp_n = 21'(b & 8'h07); ucls_n = 2'd3;
						end else begin
							berr_n = 1'b1;
						end
					end else if ((b & 8'hC0) != 8'h80) begin
						berr_n  = 1'b1;
						upend_n = 2'd0;
					end else begin
						ucp_n   = {ucp_q[14:0], b[5:0]};
						upend_n = upend_q - 2'd1;
						if (upend_n == 2'd0) begin
							case (ucls_q)
								2'd1:    min_cp = CP_MIN2;
								2'd2:    min_cp = CP_MIN3;
								default: min_cp = CP_MIN4;
							endcase
							if (ucp_n < min_cp || ucp_n > CP_MAX
								|| (ucp_n >= CP_SURR_LO && ucp_n <= CP_SURR_HI)
								|| (ucp_n >= CP_C1_LO && ucp_n <= CP_C1_HI))
								berr_n = 1'b1;
						end
					end
					// sequence cut off by the end of the name
					if (off == MidOff + 16'(nlen_q) && upend_n != 2'd0) berr_n = 1'b1;
				end
			end else if (kind_q == FK_CONFIRM && off >= CapOff) begin
				cap_n = {cap_q[55:0], b};
			end
			emit = 1'b1;
			if ({1'b0, off} + 17'd1 >= {1'b0, blen_q}) begin
				if (kind_q == FK_CONFIRM && (cap_n & ~cfg.cap_mask) != 64'd0) berr_n = 1'b1;
				r = '{b, off, kind_q, 1'b1, (berr_n ? V_INVALID : V_VALID)};
				clear_all = 1'b1;
				if (berr_n) stuck_n = 1'b1;
			end else begin
				r = '{b, off, kind_q, 1'b0, V_PROGRESS};
			end
		end

		if (clear_all) begin
			pos_n   = '0;
			hdr_n   = '0;
			kind_n  = '0;
			blen_n  = '0;
			nlen_n  = '0;
			upend_n = '0;
			ucp_n   = '0;
			ucls_n  = '0;
			cap_n   = '0;
			berr_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hdr_q   <= '0;
			kind_q  <= '0;
			blen_q  <= '0;
			nlen_q  <= '0;
			upend_q <= '0;
			ucp_q   <= '0;
			ucls_q  <= '0;
			cap_q   <= '0;
			berr_q  <= 1'b0;
			stuck_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pos_q   <= pos_n;
				hdr_q   <= hdr_n;
				kind_q  <= kind_n;
				blen_q  <= blen_n;
				nlen_q  <= nlen_n;
				upend_q <= upend_n;
				ucp_q   <= ucp_n;
				ucls_q  <= ucls_n;
				cap_q   <= cap_n;
				berr_q  <= berr_n;
				stuck_q <= stuck_n;
			end
			if (out_ready) out_valid_q <= pop && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) res_q <= r;
	end

	// end flag and verdict travel together
	a_end_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.frame_end == (res_q.verdict != V_PROGRESS)))
		else $error("frame_end and verdict disagree");

	a_stuck_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stuck_q |-> (pos_q == 16'd0 && !berr_q))
		else $error("parser state not cleared while stuck");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_item.kind == KIND_CLEAR) |=> (!stuck_q && pos_q == 16'd0))
		else $error("clear transaction did not reset the parser");

	a_in_progress_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.verdict == V_PROGRESS) |->
		(res_q.frame_kind != FK_UNKNOWN))
		else $error("body transaction without a frame type");

endmodule

[sv/pairing_frame_deframer_unit.sv]
// Channel   Dir  Handshake           Payload
// in        in   in_valid/in_stall   kind, data_byte
// out       out  out_valid/out_stall body_byte, body_offset, frame_kind, frame_end, verdict
// cfg       in   APB (psel/penable)  paddr, pwdata, prdata
// One byte per cycle sustained while out_stall is low; a result appears in the cycle after its byte leaves the queue.
// The two-entry input queue absorbs a stall of the output register.
// Clears and accepted header bytes give no result; reset restores register defaults.
// Top level: ties config registers, input queue and frame engine together. Uses pfd_pkg.
module pairing_frame_deframer_unit #(
	parameter int DIGEST_BYTES     = pfd_pkg::DigestBytesDef,
	parameter int MACHINE_ID_BYTES = pfd_pkg::MachineIdBytesDef,
	parameter int NONCE_BYTES      = pfd_pkg::NonceBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  body_byte,
	output logic [15:0] body_offset,
	output logic [2:0]  frame_kind,
	output logic        frame_end,
	output logic [1:0]  verdict,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [pfd_pkg::AddrW-1:0] paddr,
	input  logic [pfd_pkg::DataW-1:0] pwdata,
	output logic [pfd_pkg::DataW-1:0] prdata,
	output logic        pready
);
	import pfd_pkg::*;

	cfg_t    cfg;
	q_item_t in_item;
	q_item_t q_item;
	logic    q_valid;
	logic    q_pop;
	res_t    res;

	assign in_item = '{kind, data_byte};

	pfd_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	pfd_queue u_queue (
		.clk, .arst_n, .in_valid, .in_stall, .in_item, .q_valid, .q_item, .q_pop
	);

	pfd_engine #(
		.DIGEST_BYTES(DIGEST_BYTES),
		.MACHINE_ID_BYTES(MACHINE_ID_BYTES),
		.NONCE_BYTES(NONCE_BYTES)
	) u_engine (
		.clk, .arst_n, .cfg, .q_valid, .q_item, .q_pop, .out_valid, .out_stall, .res
	);

	assign body_byte   = res.body_byte;
	assign body_offset = res.body_offset;
	assign frame_kind  = res.frame_kind;
	assign frame_end   = res.frame_end;
	assign verdict     = res.verdict;

endmodule
